FILE: rtl/multi_sensor_average_hysteresis_unit_assert.svh
// assertion macros for the sensor averaging unit
`ifndef MULTI_SENSOR_AVERAGE_HYSTERESIS_UNIT_ASSERT_SVH
`define MULTI_SENSOR_AVERAGE_HYSTERESIS_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define MSAH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define MSAH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/msah_pkg.sv
// shared constants and types for the sensor averaging unit
package msah_pkg;

    // window and battery depths are powers of two
    localparam int SENSOR_COUNT  = 4;
    localparam int WINDOW_DEPTH  = 16;
    localparam int BATTERY_DEPTH = 8;

    localparam int SAMPLE_W  = 10;
    localparam int CH_W      = 3;
    localparam int LEVEL_W   = 10;
    localparam int BAT_W     = 16;
    localparam int PERIOD_W  = 16;
    localparam int MASK_W    = 4;
    localparam int THR_COUNT = 4;

    localparam int SENS_AW  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int WIN_AW   = $clog2(WINDOW_DEPTH);
    localparam int BAT_AW   = $clog2(BATTERY_DEPTH);
    localparam int SMEM_DEPTH = SENSOR_COUNT * WINDOW_DEPTH;
    localparam int SMEM_AW  = (SMEM_DEPTH > 1) ? $clog2(SMEM_DEPTH) : 1;
    localparam int WSUM_W   = SAMPLE_W + WIN_AW;
    localparam int BSUM_W   = BAT_W + BAT_AW;
    localparam int PROD_W   = 24;

    localparam int CFG_COUNT = 8;
    localparam int CFG_AW    = $clog2(CFG_COUNT);
    localparam int PADDR_W   = CFG_AW + 2;
    localparam int PDATA_W   = 32;

    localparam logic [CH_W-1:0]     BAT_CH        = CH_W'(SENSOR_COUNT);
    localparam logic [SAMPLE_W-1:0] RESET_SAMPLE  = SAMPLE_W'(512);
    localparam logic [BAT_W-1:0]    RESET_BATTERY = BAT_W'(40000);
    localparam logic [PROD_W-1:0]   BATTERY_SCALE = PROD_W'(9075);
    localparam logic [WSUM_W-1:0]   RESET_WSUM    = WSUM_W'(512 * WINDOW_DEPTH);
    localparam logic [BSUM_W-1:0]   RESET_BSUM    = BSUM_W'(40000 * BATTERY_DEPTH);

    localparam logic [SAMPLE_W-1:0] RESET_THRESHOLD = SAMPLE_W'(300);
    localparam logic [SAMPLE_W-1:0] RESET_MARGIN    = SAMPLE_W'(20);
    localparam logic [SAMPLE_W-1:0] RESET_MIN_LEVEL = SAMPLE_W'(10);
    localparam logic [PERIOD_W-1:0] RESET_PERIOD    = PERIOD_W'(100);
    localparam logic [MASK_W-1:0]   RESET_MASK      = MASK_W'(15);

    typedef enum logic [CFG_AW-1:0] {
        REG_THRESHOLD_0 = 3'd0,
        REG_THRESHOLD_1 = 3'd1,
        REG_THRESHOLD_2 = 3'd2,
        REG_THRESHOLD_3 = 3'd3,
        REG_MARGIN      = 3'd4,
        REG_MIN_LEVEL   = 3'd5,
        REG_VBAT_PERIOD = 3'd6,
        REG_STOP_MASK   = 3'd7
    } cfg_idx_t;

endpackage

FILE: rtl/msah_ifs.sv
// valid/ready channel interfaces for sample and result words
interface msah_sample_if;
    import msah_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface msah_result_if;
    import msah_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
    logic               near;
    logic               detect;
    logic               cleared;
    logic               stop_request;
    logic [BAT_W-1:0]   battery_level;

    modport source (output valid, output channel, output level, output near, output detect,
                    output cleared, output stop_request, output battery_level, input ready);
    modport sink (input valid, input channel, input level, input near, input detect,
                  input cleared, input stop_request, input battery_level, output ready);
endinterface

FILE: rtl/multi_sensor_average_hysteresis_unit.sv
// four-sensor moving average with hysteresis detect and battery averaging
//
// samples carries one 10-bit converter word per handshake; the unit keeps its own
// channel rotation (sensors 0..3, then a battery word once every vbat_period rounds)
// and the word is taken as belonging to the channel currently selected.
// results carries one word per sample: channel, window average, hysteresis state,
// detect/cleared/stop pulses and the current battery average.
// throughput: one word per cycle while results is not stalled; the sample memory is
// read when a word is accepted, written back when stage one advances, and consecutive
// words never touch the same entry. the result sits in an output register, so a new
// sample is still taken while a result waits; when results stalls with both stages
// full, samples.ready drops.
// the APB port holds thresholds, margin, min level, battery period and stop mask;
// write it only while the unit is idle.
// reset: all flags clear, sums preset to a window of 512s and a battery history of
// 40000s; memory entries read as those values until written, so no clearing pass.
module multi_sensor_average_hysteresis_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msah_pkg::PADDR_W-1:0]  paddr,
    input  logic [msah_pkg::PDATA_W-1:0]  pwdata,
    output logic [msah_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    msah_sample_if.sink                   samples,
    msah_result_if.source                 results
);
    import msah_pkg::*;

`include "multi_sensor_average_hysteresis_unit_assert.svh"

    // configuration
    logic [SAMPLE_W-1:0] threshold_reg [THR_COUNT];
    logic [SAMPLE_W-1:0] margin_reg;
    logic [SAMPLE_W-1:0] min_level_reg;
    logic [PERIOD_W-1:0] vbat_period_reg;
    logic [MASK_W-1:0]   stop_mask_reg;
    logic                cfg_we;
    cfg_idx_t            cfg_idx;

    // rotation state
    logic [CH_W-1:0]     cur_ch_reg, cur_ch_next;
    logic [WIN_AW-1:0]   win_slot_reg, win_slot_next;
    logic [PERIOD_W-1:0] countdown_reg, countdown_next;
    logic [PERIOD_W-1:0] countdown_dec;
    logic [BAT_AW-1:0]   bat_slot_reg;

    // memories
    logic [SAMPLE_W-1:0] smem [SMEM_DEPTH];
    logic                smem_valid_reg [SMEM_DEPTH];
    logic [SAMPLE_W-1:0] smem_q_reg;
    logic                smem_hit_reg;
    logic [SMEM_AW-1:0]  smem_raddr;
    logic [BAT_W-1:0]    bmem [BATTERY_DEPTH];
    logic                bmem_valid_reg [BATTERY_DEPTH];
    logic [BAT_W-1:0]    bmem_q_reg;
    logic                bmem_hit_reg;

    // stage one
    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [BAT_W-1:0]    s1_bat_v_reg;
    logic [SMEM_AW-1:0]  s1_saddr_reg;
    logic [BAT_AW-1:0]   s1_bslot_reg;

    // running state
    logic [WSUM_W-1:0]   wsum_reg [SENSOR_COUNT];
    logic                clear_flag_reg [SENSOR_COUNT];
    logic [BSUM_W-1:0]   bsum_reg;
    logic [BAT_W-1:0]    bat_avg_reg;

    // output register
    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_near_reg;
    logic                out_detect_reg;
    logic                out_cleared_reg;
    logic                out_stop_reg;
    logic [BAT_W-1:0]    out_bat_reg;

    logic                in_acc;
    logic                s1_adv;
    logic                cur_is_sensor;
    logic                s1_is_sensor;
    logic [PROD_W-1:0]   bat_prod;

    logic [SENS_AW-1:0]  s1_idx;
    logic [SAMPLE_W-1:0] old_sample;
    logic [WSUM_W-1:0]   wsum_new;
    logic [LEVEL_W-1:0]  avg;
    logic [SAMPLE_W-1:0] thr;
    logic [SAMPLE_W:0]   upper;
    logic signed [SAMPLE_W+1:0] lower;
    logic                flag_old;
    logic                flag_new;
    logic                det;
    logic                clr;
    logic [BAT_W-1:0]    old_bat;
    logic [BSUM_W-1:0]   bsum_new;
    logic [BAT_W-1:0]    bat_avg_new;

    // apb
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESHOLD_0: prdata = PDATA_W'(threshold_reg[0]);
            REG_THRESHOLD_1: prdata = PDATA_W'(threshold_reg[1]);
            REG_THRESHOLD_2: prdata = PDATA_W'(threshold_reg[2]);
            REG_THRESHOLD_3: prdata = PDATA_W'(threshold_reg[3]);
            REG_MARGIN:      prdata = PDATA_W'(margin_reg);
            REG_MIN_LEVEL:   prdata = PDATA_W'(min_level_reg);
            REG_VBAT_PERIOD: prdata = PDATA_W'(vbat_period_reg);
            REG_STOP_MASK:   prdata = PDATA_W'(stop_mask_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THR_COUNT; i++)
            begin
                threshold_reg[i] <= RESET_THRESHOLD;
            end
            margin_reg      <= RESET_MARGIN;
            min_level_reg   <= RESET_MIN_LEVEL;
            vbat_period_reg <= RESET_PERIOD;
            stop_mask_reg   <= RESET_MASK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_THRESHOLD_0: threshold_reg[0] <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD_1: threshold_reg[1] <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD_2: threshold_reg[2] <= pwdata[SAMPLE_W-1:0];
                REG_THRESHOLD_3: threshold_reg[3] <= pwdata[SAMPLE_W-1:0];
                REG_MARGIN:      margin_reg       <= pwdata[SAMPLE_W-1:0];
                REG_MIN_LEVEL:   min_level_reg    <= pwdata[SAMPLE_W-1:0];
                REG_VBAT_PERIOD: vbat_period_reg  <= pwdata[PERIOD_W-1:0];
                REG_STOP_MASK:   stop_mask_reg    <= pwdata[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshake
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign in_acc        = samples.valid && samples.ready;
    assign cur_is_sensor = (cur_ch_reg != BAT_CH);
    assign s1_is_sensor  = (s1_ch_reg != BAT_CH);

    // channel rotation
    assign countdown_dec = countdown_reg - PERIOD_W'(1);

    always_comb
    begin
        cur_ch_next    = cur_ch_reg;
        win_slot_next  = win_slot_reg;
        countdown_next = countdown_reg;
        if (32'(cur_ch_reg) + 1 < SENSOR_COUNT)
        begin
            cur_ch_next = cur_ch_reg + CH_W'(1);
        end
        else if (!cur_is_sensor)
        begin
            cur_ch_next = '0;
        end
        else
        begin
            if (countdown_dec != '0)
            begin
                countdown_next = countdown_dec;
                cur_ch_next    = '0;
            end
            else
            begin
                countdown_next = vbat_period_reg;
                cur_ch_next    = BAT_CH;
            end
            win_slot_next = (win_slot_reg == WIN_AW'(WINDOW_DEPTH - 1)) ? '0
                                                                       : win_slot_reg + WIN_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg    <= '0;
            win_slot_reg  <= '0;
            countdown_reg <= RESET_PERIOD;
            bat_slot_reg  <= '0;
        end
        else if (in_acc)
        begin
            cur_ch_reg    <= cur_ch_next;
            win_slot_reg  <= win_slot_next;
            countdown_reg <= countdown_next;
            if (!cur_is_sensor)
            begin
                bat_slot_reg <= (bat_slot_reg == BAT_AW'(BATTERY_DEPTH - 1)) ? '0
                                                                            : bat_slot_reg + BAT_AW'(1);
            end
        end
    end

    // stage one: memory reads and battery scaling
    assign smem_raddr = SMEM_AW'((32'(cur_ch_reg) << WIN_AW) | 32'(win_slot_reg));
    assign bat_prod   = PROD_W'(samples.sample) * BATTERY_SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ch_reg     <= cur_ch_reg;
            s1_sample_reg <= samples.sample;
            s1_bat_v_reg  <= bat_prod[PROD_W-1:8];
            s1_saddr_reg  <= smem_raddr;
            s1_bslot_reg  <= bat_slot_reg;
            smem_hit_reg  <= smem_valid_reg[smem_raddr];
            bmem_hit_reg  <= bmem_valid_reg[bat_slot_reg];
        end
    end

    // sample window memory
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_is_sensor)
        begin
            smem[s1_saddr_reg] <= s1_sample_reg;
        end
        if (in_acc)
        begin
            smem_q_reg <= smem[smem_raddr];
        end
    end

    // battery history memory
    always_ff @(posedge clk)
    begin
        if (s1_adv && !s1_is_sensor)
        begin
            bmem[s1_bslot_reg] <= s1_bat_v_reg;
        end
        if (in_acc)
        begin
            bmem_q_reg <= bmem[bat_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SMEM_DEPTH; i++)
            begin
                smem_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < BATTERY_DEPTH; i++)
            begin
                bmem_valid_reg[i] <= 1'b0;
            end
        end
        else if (s1_adv)
        begin
            if (s1_is_sensor)
            begin
                smem_valid_reg[s1_saddr_reg] <= 1'b1;
            end
            else
            begin
                bmem_valid_reg[s1_bslot_reg] <= 1'b1;
            end
        end
    end

    // stage two: sum update and hysteresis
    assign s1_idx     = s1_ch_reg[SENS_AW-1:0];
    assign old_sample = smem_hit_reg ? smem_q_reg : RESET_SAMPLE;
    assign wsum_new   = wsum_reg[s1_idx] - WSUM_W'(old_sample) + WSUM_W'(s1_sample_reg);
    assign avg        = wsum_new[WSUM_W-1:WIN_AW];
    assign thr        = threshold_reg[s1_ch_reg[1:0]];
    assign upper      = {1'b0, thr} + {1'b0, margin_reg};
    assign lower      = $signed({2'b00, thr}) - $signed({2'b00, margin_reg});
    assign flag_old   = clear_flag_reg[s1_idx];

    always_comb
    begin
        det      = 1'b0;
        clr      = 1'b0;
        flag_new = flag_old;
        if (!flag_old)
        begin
            if ({1'b0, avg} > upper)
            begin
                flag_new = 1'b1;
                clr      = 1'b1;
            end
        end
        else if (($signed({2'b00, avg}) < lower) && (avg > min_level_reg))
        begin
            flag_new = 1'b0;
            det      = 1'b1;
        end
    end

    assign old_bat     = bmem_hit_reg ? bmem_q_reg : RESET_BATTERY;
    assign bsum_new    = bsum_reg - BSUM_W'(old_bat) + BSUM_W'(s1_bat_v_reg);
    assign bat_avg_new = bsum_new[BSUM_W-1:BAT_AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                wsum_reg[i]       <= RESET_WSUM;
                clear_flag_reg[i] <= 1'b1;
            end
            bsum_reg    <= RESET_BSUM;
            bat_avg_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_is_sensor)
            begin
                wsum_reg[s1_idx]       <= wsum_new;
                clear_flag_reg[s1_idx] <= flag_new;
            end
            else
            begin
                bsum_reg    <= bsum_new;
                bat_avg_reg <= bat_avg_new;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_ch_reg <= s1_ch_reg;
            if (s1_is_sensor)
            begin
                out_level_reg   <= avg;
                out_near_reg    <= !flag_new;
                out_detect_reg  <= det;
                out_cleared_reg <= clr;
                out_stop_reg    <= det && stop_mask_reg[s1_ch_reg[1:0]];
                out_bat_reg     <= bat_avg_reg;
            end
            else
            begin
                out_level_reg   <= '0;
                out_near_reg    <= 1'b0;
                out_detect_reg  <= 1'b0;
                out_cleared_reg <= 1'b0;
                out_stop_reg    <= 1'b0;
                out_bat_reg     <= bat_avg_new;
            end
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.channel       = out_ch_reg;
    assign results.level         = out_level_reg;
    assign results.near          = out_near_reg;
    assign results.detect        = out_detect_reg;
    assign results.cleared       = out_cleared_reg;
    assign results.stop_request  = out_stop_reg;
    assign results.battery_level = out_bat_reg;

    // checks
    `MSAH_ASSERT_NOW(a_no_entry_overlap, clk, rst_n,
        in_acc && s1_adv && s1_is_sensor && cur_is_sensor, smem_raddr != s1_saddr_reg,
        "sample memory read and write hit the same entry")
    `MSAH_ASSERT_NEXT(a_battery_then_sensor, clk, rst_n,
        in_acc && !cur_is_sensor, cur_ch_reg == '0,
        "battery word not followed by sensor 0")
    `MSAH_ASSERT_NOW(a_channel_range, clk, rst_n,
        1'b1, cur_ch_reg <= BAT_CH,
        "channel rotation out of range")
    `MSAH_ASSERT_NOW(a_pulse_consistent, clk, rst_n,
        out_valid_reg && (out_detect_reg || out_stop_reg),
        out_near_reg && !out_cleared_reg,
        "detect or stop word without near state")

endmodule

FILE: tb/sv/tb_multi_sensor_average_hysteresis_unit.sv
// testbench for the sensor averaging unit: directed table, random phases, self-checking
module tb_multi_sensor_average_hysteresis_unit;
    import msah_pkg::*;

    localparam int CYCLE_LIMIT     = 150000;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int DIR_ROWS        = 24;
    localparam int MAX_REPORTS     = 10;
    localparam int PERIOD_PLAN [1:PHASE_COUNT] = '{3, 1, 2, 1, 1, 2, 0, 65535};

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic               near;
        logic               detect;
        logic               cleared;
        logic               stop_request;
        logic [BAT_W-1:0]   battery_level;
    } result_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        logic [CH_W-1:0]     ch;
        logic [LEVEL_W-1:0]  lvl;
    } dir_row_t;

    // first round after reset has typed expectations
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{10'd0,     1'b1, 3'd0, 10'd480},
        '{10'd1023,  1'b1, 3'd1, 10'd543},
        '{10'd0,     1'b1, 3'd2, 10'd480},
        '{10'd1023,  1'b1, 3'd3, 10'd543},
        '{10'd1023,  1'b0, 3'd0, 10'd0},
        '{10'd0,     1'b0, 3'd0, 10'd0},
        '{10'd1023,  1'b0, 3'd0, 10'd0},
        '{10'd0,     1'b0, 3'd0, 10'd0},
        '{10'h155,   1'b0, 3'd0, 10'd0},
        '{10'h2aa,   1'b0, 3'd0, 10'd0},
        '{10'h155,   1'b0, 3'd0, 10'd0},
        '{10'h2aa,   1'b0, 3'd0, 10'd0},
        '{10'h2aa,   1'b0, 3'd0, 10'd0},
        '{10'h155,   1'b0, 3'd0, 10'd0},
        '{10'h2aa,   1'b0, 3'd0, 10'd0},
        '{10'h155,   1'b0, 3'd0, 10'd0},
        '{10'd1,     1'b0, 3'd0, 10'd0},
        '{10'd1022,  1'b0, 3'd0, 10'd0},
        '{10'd512,   1'b0, 3'd0, 10'd0},
        '{10'd511,   1'b0, 3'd0, 10'd0},
        '{10'd0,     1'b0, 3'd0, 10'd0},
        '{10'd0,     1'b0, 3'd0, 10'd0},
        '{10'd1023,  1'b0, 3'd0, 10'd0},
        '{10'd1023,  1'b0, 3'd0, 10'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    msah_sample_if smp_if ();
    msah_result_if res_if ();

    multi_sensor_average_hysteresis_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (smp_if),
        .results (res_if)
    );

    // predictor copy of registers and state
    logic [SAMPLE_W-1:0] thr_reg [THR_COUNT];
    logic [SAMPLE_W-1:0] margin_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [MASK_W-1:0]   mask_reg;

    logic [SAMPLE_W-1:0] win_mem [SENSOR_COUNT][WINDOW_DEPTH];
    logic [WSUM_W-1:0]   win_sum [SENSOR_COUNT];
    logic                is_clear [SENSOR_COUNT];
    logic [CH_W-1:0]     cur_chan;
    logic [WIN_AW-1:0]   win_pos;
    logic [PERIOD_W-1:0] bat_countdown;
    logic [BAT_W-1:0]    bat_mem [BATTERY_DEPTH];
    logic [BSUM_W-1:0]   bat_sum;
    logic [BAT_AW-1:0]   bat_pos;
    logic [BAT_W-1:0]    bat_avg;

    result_word_t pending_words [$];
    int cycle_count = 0;
    int n_mismatch = 0;
    int n_samples = 0;
    int n_battery = 0;
    int n_detect = 0;
    int n_clear = 0;
    int n_stop = 0;
    int rx_hold_req = 0;
    bit tx_quiet = 1'b0;
    int aim [SENSOR_COUNT];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                 pending_words.size());
        $display("tb_multi_sensor_average_hysteresis_unit: FAIL");
        $finish;
    end

    function automatic result_word_t next_result_word(input logic [SAMPLE_W-1:0] s);
        result_word_t r;
        logic [CH_W-1:0] ch;
        logic [SENS_AW-1:0] si;
        logic [31:0] prod;
        logic [BAT_W-1:0] v;
        int avg;
        int t;
        int m;
        r = '0;
        ch = cur_chan;
        si = ch[SENS_AW-1:0];
        if (int'(ch) < SENSOR_COUNT)
        begin
            win_sum[si] = win_sum[si] - WSUM_W'(win_mem[si][win_pos]) + WSUM_W'(s);
            win_mem[si][win_pos] = s;
            avg = int'(win_sum[si] >> WIN_AW);
            t = int'(thr_reg[si]);
            m = int'(margin_reg);
            if (!is_clear[si])
            begin
                if (avg > t + m)
                begin
                    is_clear[si] = 1'b1;
                    r.cleared = 1'b1;
                end
            end
            else if (avg < t - m && avg > int'(min_reg))
            begin
                is_clear[si] = 1'b0;
                r.detect = 1'b1;
                r.stop_request = mask_reg[si];
            end
            r.level = LEVEL_W'(avg);
            r.near = !is_clear[si];
        end
        else
        begin
            prod = 32'(s) * 32'd9075;
            v = prod[BAT_W+7:8];
            bat_sum = bat_sum - BSUM_W'(bat_mem[bat_pos]) + BSUM_W'(v);
            bat_mem[bat_pos] = v;
            bat_pos = bat_pos + BAT_AW'(1);
            bat_avg = BAT_W'(bat_sum >> BAT_AW);
        end
        r.channel = ch;
        r.battery_level = bat_avg;

        // channel rotation
        if (int'(ch) + 1 < SENSOR_COUNT)
        begin
            cur_chan = ch + CH_W'(1);
        end
        else if (int'(ch) >= SENSOR_COUNT)
        begin
            cur_chan = '0;
        end
        else
        begin
            bat_countdown = bat_countdown - PERIOD_W'(1);
            if (bat_countdown != '0)
            begin
                cur_chan = '0;
            end
            else
            begin
                bat_countdown = period_reg;
                cur_chan = BAT_CH;
            end
            win_pos = win_pos + WIN_AW'(1);
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD_0: thr_reg[0] = data[SAMPLE_W-1:0];
            REG_THRESHOLD_1: thr_reg[1] = data[SAMPLE_W-1:0];
            REG_THRESHOLD_2: thr_reg[2] = data[SAMPLE_W-1:0];
            REG_THRESHOLD_3: thr_reg[3] = data[SAMPLE_W-1:0];
            REG_MARGIN:      margin_reg = data[SAMPLE_W-1:0];
            REG_MIN_LEVEL:   min_reg = data[SAMPLE_W-1:0];
            REG_VBAT_PERIOD: period_reg = data[PERIOD_W-1:0];
            REG_STOP_MASK:   mask_reg = data[MASK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input result_word_t typed_word);
        int gap;
        result_word_t w;
        if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 4));
        if (gap > 0)
        begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample <= s;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        w = next_result_word(s);
        pending_words.push_back(typed ? typed_word : w);
        n_samples++;
        if (int'(w.channel) >= SENSOR_COUNT) n_battery++;
        n_detect += w.detect;
        n_clear += w.cleared;
        n_stop += w.stop_request;
    endtask

    task automatic drain_results(input int settle);
        smp_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // result word receiver and checker
    initial
    begin
        int rx_gap;
        int hold_left;
        bit rx_quiet;
        result_word_t got;
        result_word_t want;
        rx_gap = 0;
        hold_left = 0;
        rx_quiet = 1'b0;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                got = '{channel: res_if.channel, level: res_if.level, near: res_if.near,
                        detect: res_if.detect, cleared: res_if.cleared,
                        stop_request: res_if.stop_request,
                        battery_level: res_if.battery_level};
                if (pending_words.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: unexpected result word %p", $time, got);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got.channel !== want.channel || got.level !== want.level ||
                        got.near !== want.near || got.detect !== want.detect ||
                        got.cleared !== want.cleared ||
                        got.stop_request !== want.stop_request ||
                        got.battery_level !== want.battery_level)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
                if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
                rx_gap = rx_quiet ? 0 : int'($urandom_range(0, 4));
            end
            if (rx_hold_req > 0)
            begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [PDATA_W-1:0] regval [CFG_COUNT];
        logic [PDATA_W-1:0] field_mask;
        logic [SAMPLE_W-1:0] s;
        result_word_t tw;
        int c;
        int v;
        int t;
        int m;

        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        smp_if.valid <= 1'b0;
        smp_if.sample <= '0;

        for (int i = 0; i < THR_COUNT; i++) thr_reg[i] = RESET_THRESHOLD;
        margin_reg = RESET_MARGIN;
        min_reg = RESET_MIN_LEVEL;
        period_reg = RESET_PERIOD;
        mask_reg = RESET_MASK;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++) win_mem[i][k] = RESET_SAMPLE;
            win_sum[i] = RESET_WSUM;
            is_clear[i] = 1'b1;
            aim[i] = 512;
        end
        cur_chan = '0;
        win_pos = '0;
        bat_countdown = RESET_PERIOD;
        for (int k = 0; k < BATTERY_DEPTH; k++) bat_mem[k] = RESET_BATTERY;
        bat_sum = RESET_BSUM;
        bat_pos = '0;
        bat_avg = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            tw = '0;
            tw.channel = dir_rows[i].ch;
            tw.level = dir_rows[i].lvl;
            send_sample(dir_rows[i].sample, dir_rows[i].typed, tw);
        end

        for (int p = 0; p <= PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                drain_results(4);
                regval[REG_THRESHOLD_0] = $urandom_range(150, 750);
                regval[REG_THRESHOLD_1] = $urandom_range(150, 750);
                regval[REG_THRESHOLD_2] = $urandom_range(150, 750);
                regval[REG_THRESHOLD_3] = $urandom_range(150, 750);
                regval[REG_MARGIN] = $urandom_range(0, 60);
                regval[REG_MIN_LEVEL] = $urandom_range(0, 120);
                regval[REG_VBAT_PERIOD] = PERIOD_PLAN[p];
                regval[REG_STOP_MASK] = $urandom_range(0, 15);
                case (p)
                    3:
                    begin
                        // near sensors can never clear, nothing can detect
                        for (int r = REG_THRESHOLD_0; r <= REG_THRESHOLD_3; r++)
                            regval[r] = 1023;
                        regval[REG_MARGIN] = 1023;
                        regval[REG_MIN_LEVEL] = 0;
                        regval[REG_STOP_MASK] = 15;
                    end
                    4:
                    begin
                        for (int r = REG_THRESHOLD_0; r <= REG_THRESHOLD_3; r++)
                            regval[r] = 0;
                        regval[REG_MARGIN] = 0;
                        regval[REG_MIN_LEVEL] = 0;
                        regval[REG_STOP_MASK] = 0;
                    end
                    5:
                    begin
                        // margin above some thresholds
                        regval[REG_THRESHOLD_0] = 100;
                        regval[REG_THRESHOLD_1] = 600;
                        regval[REG_THRESHOLD_2] = 900;
                        regval[REG_THRESHOLD_3] = 50;
                        regval[REG_MARGIN] = 300;
                        regval[REG_MIN_LEVEL] = 0;
                    end
                    6: regval[REG_MIN_LEVEL] = 1023;
                    8: regval[REG_STOP_MASK] = 0;
                    default: ;
                endcase
                // junk in the unused upper bits
                if (p == 1 || p == 2 || p == 7)
                begin
                    for (int r = 0; r < CFG_COUNT; r++)
                    begin
                        field_mask = (r == REG_VBAT_PERIOD) ? 32'h0000_ffff :
                                     (r == REG_STOP_MASK) ? 32'h0000_000f : 32'h0000_03ff;
                        regval[r] = regval[r] | ($urandom() & ~field_mask);
                    end
                end
                for (int r = 0; r < CFG_COUNT; r++) write_reg(cfg_idx_t'(r), regval[r]);
                if (p == 1 || p == 5) rx_hold_req = 80;
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (int'(cur_chan) >= SENSOR_COUNT)
                begin
                    if ($urandom_range(0, 7) == 0)
                        s = $urandom_range(0, 1) ? '1 : '0;
                    else
                        s = SAMPLE_W'($urandom_range(0, 1023));
                end
                else
                begin
                    c = int'(cur_chan);
                    if ($urandom_range(0, 23) == 0)
                    begin
                        t = int'(thr_reg[c]);
                        m = int'(margin_reg);
                        case ($urandom_range(0, 5))
                            0: v = $urandom_range(0, 1023);
                            1: v = t - m - int'($urandom_range(2, 40));
                            2: v = t + m + int'($urandom_range(2, 40));
                            3: v = 0;
                            4: v = 1023;
                            default: v = int'(min_reg) + int'($urandom_range(0, 6));
                        endcase
                        aim[c] = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
                    end
                    if ($urandom_range(0, 9) == 0)
                        v = $urandom_range(0, 1023);
                    else
                        v = aim[c] + int'($urandom_range(0, 16)) - 8;
                    v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
                    s = SAMPLE_W'(v);
                end
                send_sample(s, 1'b0, '0);
            end
        end

        drain_results(8);
        $display("run covered %0d sample words (%0d battery) over %0d register settings",
                 n_samples, n_battery, PHASE_COUNT + 1);
        $display("saw %0d detects, %0d clears, %0d stop requests; %0d mismatches",
                 n_detect, n_clear, n_stop, n_mismatch);
        if (n_mismatch == 0)
            $display("tb_multi_sensor_average_hysteresis_unit: PASS");
        else
            $display("tb_multi_sensor_average_hysteresis_unit: FAIL");
        $finish;
    end

endmodule
